### rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  localparam int unsigned COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [COUNT_W-1:0] ENTRY_POS_RESET = 10'd2;

  // accepted message codes
  localparam logic [7:0] MC_DATA_REQ = 8'h11;
  localparam logic [7:0] MC_DATA_IND = 8'h29;
  localparam logic [7:0] MC_DATA_CON = 8'h2e;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_BAD_VALUE   = 2'd3;

  // group value commands
  localparam logic [3:0] CMD_READ     = 4'd0;
  localparam logic [3:0] CMD_RESPONSE = 4'd1;
  localparam logic [3:0] CMD_WRITE    = 4'd2;

  // offsets of the fixed fields after the additional information
  localparam logic [COUNT_W-1:0] OFS_CTRL1   = 10'd0;
  localparam logic [COUNT_W-1:0] OFS_CTRL2   = 10'd1;
  localparam logic [COUNT_W-1:0] OFS_SRC_HI  = 10'd2;
  localparam logic [COUNT_W-1:0] OFS_SRC_LO  = 10'd3;
  localparam logic [COUNT_W-1:0] OFS_DST_HI  = 10'd4;
  localparam logic [COUNT_W-1:0] OFS_DST_LO  = 10'd5;
  localparam logic [COUNT_W-1:0] OFS_NPDU    = 10'd6;
  localparam logic [COUNT_W-1:0] OFS_TPCI    = 10'd7;
  localparam logic [COUNT_W-1:0] OFS_APCI    = 10'd8;
  localparam logic [COUNT_W-1:0] FIXED_BYTES = 10'd9;

  localparam logic [7:0] STD_MAX_NPDU = 8'd15;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         code;
    logic [COUNT_W-1:0] info_end;
    logic               entry_error;
    logic [7:0]         control_one;
    logic [7:0]         control_two;
    logic [15:0]        source;
    logic [15:0]        destination;
    logic [7:0]         npdu_length;
    logic [7:0]         tpci;
    logic [7:0]         apci;
  } frame_view_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         message_code;
    logic [1:0]         command;
    logic [5:0]         small_value;
    logic [2:0]         hop_count;
    logic [15:0]        source_address;
    logic [15:0]        destination_address;
    logic [COUNT_W-1:0] payload_start;
    logic [7:0]         payload_length;
    logic               group_flag;
    logic               confirm_flag;
  } frame_result_t;

endpackage

`default_nettype wire

### rtl/cfp_track.sv
`default_nettype none

module cfp_track (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 take,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  output cfp_pkg::frame_view_t view
);
  import cfp_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         code_reg;
  logic [COUNT_W-1:0] info_end;
  logic [COUNT_W-1:0] next_entry_pos;
  logic               entry_error;
  logic [7:0]         control_one;
  logic [7:0]         control_two;
  logic [15:0]        source_reg;
  logic [15:0]        destination_reg;
  logic [7:0]         npdu_length;
  logic [7:0]         tpci_byte;
  logic [7:0]         apci_byte;

  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         code_reg_next;
  logic [COUNT_W-1:0] info_end_next;
  logic [COUNT_W-1:0] next_entry_pos_next;
  logic               entry_error_next;
  logic [7:0]         control_one_next;
  logic [7:0]         control_two_next;
  logic [15:0]        source_reg_next;
  logic [15:0]        destination_reg_next;
  logic [7:0]         npdu_length_next;
  logic [7:0]         tpci_byte_next;
  logic [7:0]         apci_byte_next;

  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] b_ext;
  logic [COUNT_W-1:0] ofs;
  logic [COUNT_W-1:0] entry_room;

  always_comb begin
    pos        = byte_count;
    b_ext      = {{(COUNT_W-8){1'b0}}, data_byte};
    ofs        = pos - info_end;
    entry_room = info_end - next_entry_pos - 10'd2;

    code_reg_next        = code_reg;
    info_end_next        = info_end;
    next_entry_pos_next  = next_entry_pos;
    entry_error_next     = entry_error;
    control_one_next     = control_one;
    control_two_next     = control_two;
    source_reg_next      = source_reg;
    destination_reg_next = destination_reg;
    npdu_length_next     = npdu_length;
    tpci_byte_next       = tpci_byte;
    apci_byte_next       = apci_byte;

    if (pos == 10'd0) begin
      code_reg_next = data_byte;
    end else if (pos == 10'd1) begin
      info_end_next = b_ext + 10'd2;
    end else if (pos < info_end) begin
      // type-length walk over the additional information
      if (!entry_error) begin
        if (pos == next_entry_pos) begin
          if (pos + 10'd1 == info_end) entry_error_next = 1'b1;
        end else if (pos == next_entry_pos + 10'd1) begin
          if (b_ext > entry_room) entry_error_next = 1'b1;
          else next_entry_pos_next = next_entry_pos + 10'd2 + b_ext;
        end
      end
    end else begin
      unique case (ofs)
        OFS_CTRL1:  control_one_next = data_byte;
        OFS_CTRL2:  control_two_next = data_byte;
        OFS_SRC_HI: source_reg_next[15:8] = data_byte;
        OFS_SRC_LO: source_reg_next[7:0] = data_byte;
        OFS_DST_HI: destination_reg_next[15:8] = data_byte;
        OFS_DST_LO: destination_reg_next[7:0] = data_byte;
        OFS_NPDU:   npdu_length_next = data_byte;
        OFS_TPCI:   tpci_byte_next = data_byte;
        OFS_APCI:   apci_byte_next = data_byte;
        default: ;
      endcase
    end

    byte_count_next = (pos == COUNT_MAX) ? COUNT_MAX : pos + 10'd1;

    view.byte_count  = byte_count_next;
    view.code        = code_reg_next;
    view.info_end    = info_end_next;
    view.entry_error = entry_error_next;
    view.control_one = control_one_next;
    view.control_two = control_two_next;
    view.source      = source_reg_next;
    view.destination = destination_reg_next;
    view.npdu_length = npdu_length_next;
    view.tpci        = tpci_byte_next;
    view.apci        = apci_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_count      <= '0;
      code_reg        <= '0;
      info_end        <= '0;
      next_entry_pos  <= ENTRY_POS_RESET;
      entry_error     <= 1'b0;
      control_one     <= '0;
      control_two     <= '0;
      source_reg      <= '0;
      destination_reg <= '0;
      npdu_length     <= '0;
      tpci_byte       <= '0;
      apci_byte       <= '0;
    end else if (take) begin
      byte_count      <= byte_count_next;
      code_reg        <= code_reg_next;
      info_end        <= info_end_next;
      next_entry_pos  <= next_entry_pos_next;
      entry_error     <= entry_error_next;
      control_one     <= control_one_next;
      control_two     <= control_two_next;
      source_reg      <= source_reg_next;
      destination_reg <= destination_reg_next;
      npdu_length     <= npdu_length_next;
      tpci_byte       <= tpci_byte_next;
      apci_byte       <= apci_byte_next;
    end
  end

endmodule

`default_nettype wire

### rtl/cfp_judge.sv
`default_nettype none

module cfp_judge (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  wire cfp_pkg::frame_view_t view,
  input  wire                   out_ready,
  output logic                  out_valid,
  output cfp_pkg::frame_result_t result
);
  import cfp_pkg::*;

  logic [1:0]         status;
  logic [3:0]         cmd;
  logic [COUNT_W-1:0] fixed_end;
  logic [COUNT_W:0]   expected_len;
  logic               code_ok;
  frame_result_t      result_next;

  always_comb begin
    cmd          = {view.tpci[1:0], view.apci[7:6]};
    fixed_end    = view.info_end + FIXED_BYTES;
    expected_len = {1'b0, view.info_end} + 11'd8 + {3'b000, view.npdu_length};
    code_ok      = (view.code == MC_DATA_REQ) || (view.code == MC_DATA_IND) ||
                   (view.code == MC_DATA_CON);

    if (view.byte_count < 10'd2) status = ST_BAD_LENGTH;
    else if (!code_ok) status = ST_UNSUPPORTED;
    else if (view.byte_count < fixed_end) status = ST_BAD_LENGTH;
    else if (view.entry_error) status = ST_BAD_LENGTH;
    else if ((view.npdu_length == 8'd0) || ({1'b0, view.byte_count} != expected_len))
      status = ST_BAD_LENGTH;
    else if (view.control_one[7] && (view.npdu_length > STD_MAX_NPDU))
      status = ST_BAD_LENGTH;
    else if (view.control_one[6] || (view.control_two[3:0] != 4'd0))
      status = ST_UNSUPPORTED;
    else if (view.tpci[7:2] != 6'd0) status = ST_UNSUPPORTED;
    else if (cmd > CMD_WRITE) status = ST_UNSUPPORTED;
    else if ((cmd == CMD_READ) &&
             ((view.npdu_length != 8'd1) || (view.apci[5:0] != 6'd0)))
      status = ST_BAD_VALUE;
    else if ((view.npdu_length > 8'd1) && (view.apci[5:0] != 6'd0))
      status = ST_BAD_VALUE;
    else status = ST_OK;

    result_next = '0;
    result_next.status = status;
    if (status == ST_OK) begin
      result_next.message_code        = view.code;
      result_next.command             = cmd[1:0];
      result_next.small_value         = view.apci[5:0];
      result_next.hop_count           = view.control_two[6:4];
      result_next.source_address      = view.source;
      result_next.destination_address = view.destination;
      result_next.payload_start       = fixed_end;
      result_next.payload_length      = view.npdu_length - 8'd1;
      result_next.group_flag          = view.control_two[7];
      result_next.confirm_flag        = view.control_one[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= result_next;
  end

endmodule

`default_nettype wire

### rtl/cemi_frame_parser.sv
// cemi_frame_parser: checks and decodes one cEMI frame given a byte at a time.
// input stream: s_tdata carries one frame byte, s_tlast marks the last byte.
// output stream: one transaction per frame, sent after its last byte; m_tuser
// holds the status, m_tdata the decoded fields (all zero unless status is ok).
// bytes are taken one per cycle with no gaps inside or between frames while no
// last byte waits for the result register; every byte is first captured in an
// input register, then folded into the frame state by a single combinational
// pass. m_tvalid rises once the last byte has passed the input register and
// then the result register; the result is taken while m_tready is high.
// a stalled result holds in the result register; bytes that are not last
// keep flowing, and a second last byte waits in the input register until the
// result has been taken, which drops s_tready.
// reset clears the frame state and both valid flags; the first byte after
// reset starts a new frame. after each last byte the state returns to its
// reset values for the next frame.
`default_nettype none

module cemi_frame_parser (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte
  input  wire         s_tlast,   // last_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // message_code, command, small_value, hop_count,
                                 // source_address, destination_address,
                                 // payload_start, payload_length, group_flag,
                                 // confirm_flag, zero fill
  output logic [1:0]  m_tuser    // status
);
  import cfp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_data;
  logic          in_last;
  logic          advance;
  frame_view_t   view;
  frame_result_t result;

  // a last byte needs a free result register
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  cfp_track u_track (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .data_byte (in_data),
    .last_byte (in_last),
    .view      (view)
  );

  cfp_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && in_last),
    .view      (view),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .result    (result)
  );

  assign m_tuser = result.status;
  assign m_tdata = {1'b0,
                    result.confirm_flag,
                    result.group_flag,
                    result.payload_length,
                    result.payload_start,
                    result.destination_address,
                    result.source_address,
                    result.hop_count,
                    result.small_value,
                    result.command,
                    result.message_code};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while a last byte is stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> m_tvalid)
    else $error("last byte did not produce a result");

  a_held_byte_stable: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_data) && $stable(in_last)))
    else $error("held input byte changed");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("failed frame carries nonzero fields");

endmodule

`default_nettype wire
